### design/rpr_pkg.sv
// ----------------------------------------------------------------------------
// rpr_pkg
// Types and constants shared by the rosy pair rotation match core.
// ----------------------------------------------------------------------------
package rpr_pkg;

  typedef struct packed {
    logic signed [15:0] target_vec_x;
    logic signed [15:0] target_vec_y;
    logic signed [15:0] target_vec_z;
    logic signed [15:0] target_norm_x;
    logic signed [15:0] target_norm_y;
    logic signed [15:0] target_norm_z;
    logic signed [15:0] source_vec_x;
    logic signed [15:0] source_vec_y;
    logic signed [15:0] source_vec_z;
    logic signed [15:0] source_norm_x;
    logic signed [15:0] source_norm_y;
    logic signed [15:0] source_norm_z;
  } rpr_in_t;

  typedef struct packed {
    logic signed [15:0] best_x;
    logic signed [15:0] best_y;
    logic signed [15:0] best_z;
    logic [1:0]         target_turns;
    logic [1:0]         source_turns;
  } rpr_out_t;

  typedef logic signed [15:0] vec3_t [3];

  localparam logic [15:0]        MARGIN_RESET = 16'd268;
  localparam logic signed [35:0] BEST_INIT    = -36'sd536870912;

endpackage

### design/rosy_pair_rotation_match_core.sv
// ----------------------------------------------------------------------------
// rosy_pair_rotation_match_core
// Four-way symmetric orientation match of a target and a source tangent.
// ----------------------------------------------------------------------------
// Usage: drive in_data and pulse start while busy is low; a transfer takes
// place at that edge. busy is tied low: one item can be taken every cycle.
// The result appears on out_data with out_valid high for exactly one cycle,
// once the item has passed every stage; results leave in the order items came.
// The pipeline has 3 rotation stages, 1 rounding stage, 1 dot-product
// multiply stage, 1 sum stage and 4 selection stages, one per target turn;
// the last selection register drives out_data.
// Throughput is one item per cycle.
// cfg_we/cfg_wdata write tie_margin (reset value 268); write only when idle.
// Reset clears the valid pipeline and restores the margin to 268; the
// receiver cannot stall, so nothing holds results back.
// ----------------------------------------------------------------------------
module rosy_pair_rotation_match_core
  import rpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  rpr_in_t     in_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic        out_valid,
  output rpr_out_t    out_data
);

  logic [15:0] margin_r;
  logic [9:0]  vld_r;
  logic signed [15:0] trot [4][3];
  logic signed [15:0] srot [4][3];
  logic signed [15:0] tr_r [4][3];
  logic signed [15:0] sr_r [4][3];
  logic signed [15:0] sr2_r [4][3];
  logic signed [15:0] sr3_r [4][3];
  logic signed [31:0] pr_r [16][3];
  logic signed [33:0] dp_r [16];
  logic signed [35:0] best_r [3];
  rpr_out_t           sel_r [4];
  logic signed [33:0] dpd_r [3][16];
  logic signed [15:0] srd_r [3][4][3];
  logic signed [35:0] best_in [4];
  rpr_out_t           res_in [4];
  logic signed [33:0] dp_in [4][16];
  logic signed [15:0] sr_in [4][4][3];
  logic signed [35:0] best_nxt [4];
  rpr_out_t           res_nxt [4];

  assign busy = 1'b0;

  rpr_rotate u_trot (
    .clk(clk),
    .v_x(in_data.target_vec_x), .v_y(in_data.target_vec_y),
    .v_z(in_data.target_vec_z),
    .n_x(in_data.target_norm_x), .n_y(in_data.target_norm_y),
    .n_z(in_data.target_norm_z),
    .rot(trot)
  );

  rpr_rotate u_srot (
    .clk(clk),
    .v_x(in_data.source_vec_x), .v_y(in_data.source_vec_y),
    .v_z(in_data.source_vec_z),
    .n_x(in_data.source_norm_x), .n_y(in_data.source_norm_y),
    .n_z(in_data.source_norm_z),
    .rot(srot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= MARGIN_RESET;
      vld_r    <= '0;
    end else begin
      if (cfg_we) margin_r <= cfg_wdata;
      vld_r <= {vld_r[8:0], start};
    end
  end

  always_ff @(posedge clk) begin
    tr_r  <= trot;
    sr_r  <= srot;
    sr2_r <= sr_r;
    sr3_r <= sr2_r;
    for (int k = 0; k < 4; k++)
      for (int l = 0; l < 4; l++)
        for (int i = 0; i < 3; i++)
          pr_r[4*k+l][i] <= tr_r[k][i] * sr_r[l][i];
    for (int p = 0; p < 16; p++)
      dp_r[p] <= 34'(pr_r[p][0]) + 34'(pr_r[p][1]) + 34'(pr_r[p][2]);
    for (int j = 0; j < 3; j++) begin
      best_r[j] <= best_nxt[j];
      dpd_r[j]  <= dp_in[j];
      srd_r[j]  <= sr_in[j];
    end
    for (int j = 0; j < 4; j++) sel_r[j] <= res_nxt[j];
  end

  always_comb begin
    best_in[0] = BEST_INIT;
    res_in[0]  = '0;
    dp_in[0]   = dp_r;
    sr_in[0]   = sr3_r;
    for (int j = 1; j < 4; j++) begin
      best_in[j] = best_r[j-1];
      res_in[j]  = sel_r[j-1];
      dp_in[j]   = dpd_r[j-1];
      sr_in[j]   = srd_r[j-1];
    end
  end

  // one target turn per stage, source turns in order
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      best_nxt[j] = best_in[j];
      res_nxt[j]  = res_in[j];
      for (int l = 0; l < 4; l++) begin
        if (36'(dp_in[j][4*j+l]) > best_nxt[j] + $signed(36'(margin_r))) begin
          best_nxt[j]              = 36'(dp_in[j][4*j+l]);
          res_nxt[j].best_x       = sr_in[j][l][0];
          res_nxt[j].best_y       = sr_in[j][l][1];
          res_nxt[j].best_z       = sr_in[j][l][2];
          res_nxt[j].target_turns = 2'(j);
          res_nxt[j].source_turns = 2'(l);
        end
      end
    end
  end

  assign out_valid = vld_r[9];
  assign out_data  = sel_r[3];

endmodule

### design/rpr_rotate.sv
// ----------------------------------------------------------------------------
// rpr_rotate
// Three-stage pipeline: one vector turned by 0..3 quarter turns about its
// normal, giving all four rotations in Q2.14, the turned ones rounded and saturated.
// ----------------------------------------------------------------------------
module rpr_rotate
  import rpr_pkg::*;
(
  input  logic               clk,
  input  logic signed [15:0] v_x,
  input  logic signed [15:0] v_y,
  input  logic signed [15:0] v_z,
  input  logic signed [15:0] n_x,
  input  logic signed [15:0] n_y,
  input  logic signed [15:0] n_z,
  output logic signed [15:0] rot [4][3]
);

  // stage 1: products
  logic signed [31:0] pnv_r [3];
  logic signed [31:0] pc_r [6];
  logic signed [15:0] v1_r [3];
  logic signed [15:0] n1_r [3];
  // stage 2: n.v and cross
  logic signed [33:0] nd_r;
  logic signed [32:0] cr_r [3];
  logic signed [15:0] v2_r [3];
  logic signed [15:0] n2_r [3];
  // stage 3: n*(n.v)
  logic signed [49:0] nn_r [3];
  logic signed [32:0] cr3_r [3];
  logic signed [15:0] v3_r [3];

  always_ff @(posedge clk) begin
    v1_r[0] <= v_x; v1_r[1] <= v_y; v1_r[2] <= v_z;
    n1_r[0] <= n_x; n1_r[1] <= n_y; n1_r[2] <= n_z;
    pnv_r[0] <= n_x * v_x;
    pnv_r[1] <= n_y * v_y;
    pnv_r[2] <= n_z * v_z;
    pc_r[0] <= n_y * v_z;
    pc_r[1] <= n_z * v_y;
    pc_r[2] <= n_z * v_x;
    pc_r[3] <= n_x * v_z;
    pc_r[4] <= n_x * v_y;
    pc_r[5] <= n_y * v_x;
    nd_r <= 34'(pnv_r[0]) + 34'(pnv_r[1]) + 34'(pnv_r[2]);
    cr_r[0] <= 33'(pc_r[0]) - 33'(pc_r[1]);
    cr_r[1] <= 33'(pc_r[2]) - 33'(pc_r[3]);
    cr_r[2] <= 33'(pc_r[4]) - 33'(pc_r[5]);
    v2_r <= v1_r;
    n2_r <= n1_r;
    for (int i = 0; i < 3; i++) nn_r[i] <= n2_r[i] * nd_r;
    cr3_r <= cr_r;
    v3_r <= v2_r;
  end

  function automatic logic signed [15:0] rnd_sat(input logic signed [51:0] s);
    logic signed [51:0] t;
    logic signed [23:0] q;
    t = s + 52'sd134217728;
    q = t[51:28];
    if (q > 24'sd32767) return 16'sh7fff;
    if (q < -24'sd32768) return 16'sh8000;
    return q[15:0];
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rot[0][i] = v3_r[i];
      rot[1][i] = rnd_sat(52'(nn_r[i]) + (52'(cr3_r[i]) <<< 14));
      rot[2][i] = rnd_sat((52'(nn_r[i]) <<< 1) - (52'(v3_r[i]) <<< 28));
      rot[3][i] = rnd_sat(52'(nn_r[i]) - (52'(cr3_r[i]) <<< 14));
    end
  end

endmodule
